@@ rtl/core/scfs_pkg.sv @@
package scfs_pkg;

  localparam int FreqW   = 11;
  localparam int NextW   = FreqW + 1;
  localparam int OpW     = 3;
  localparam int PeriodW = 3;
  localparam int ShiftW  = 3;
  localparam int CountW  = 4;

  localparam logic [OpW-1:0] OpTick    = 3'd0;
  localparam logic [OpW-1:0] OpTrigger = 3'd1;
  localparam logic [OpW-1:0] OpPeriod  = 3'd2;
  localparam logic [OpW-1:0] OpNegate  = 3'd3;
  localparam logic [OpW-1:0] OpShift   = 3'd4;

  localparam logic [NextW-1:0]  SubWrap     = 12'h800;
  localparam logic [CountW-1:0] CountIdle   = 4'd8;

endpackage

@@ rtl/core/scfs_calc.sv @@
module scfs_calc (
  input  logic [scfs_pkg::FreqW-1:0]  freq,
  input  logic [scfs_pkg::ShiftW-1:0] shift,
  input  logic                        sub,
  output logic [scfs_pkg::NextW-1:0]  next_freq
);

  logic [scfs_pkg::FreqW-1:0] step;
  logic [scfs_pkg::NextW-1:0] sum;
  logic [scfs_pkg::NextW-1:0] diff;

  assign step = freq >> shift;
  assign sum  = {1'b0, freq} + {1'b0, step};
  assign diff = {1'b0, freq} - {1'b0, step};

  always_comb begin
    if (!sub) begin
      next_freq = sum;
    end else if (step[scfs_pkg::FreqW-1]) begin
      next_freq = sum - scfs_pkg::SubWrap;
    end else begin
      next_freq = diff;
    end
  end

endmodule

@@ rtl/core/square_channel_frequency_sweep_core.sv @@
// Frequency sweep for a square-wave sound channel.
// Input channel (in_valid/in_ready) carries one opcode per transfer: sweep
// tick, trigger (captures trigger_freq as the shadow frequency), or a write
// of the sweep period, negate bit or shift. Unused opcodes leave the state
// alone. Every input transfer yields exactly one output transfer
// (out_valid/out_ready) with the frequency write strobe, the shadow
// frequency, the channel-off strobe and the enable and overflow flags.
// The result passes through the input register, then the result register.
// Throughput: one item per cycle while out_ready stays high; the sweep
// arithmetic (shift, add or subtract, second recompute) sits between the
// two registers.
// Reset: synchronous on rst; all sweep state clears, the sweep is enabled
// with both overflow flags clear, and neither channel holds a transfer.
// Stall: while out_ready is low the result holds; the input register still
// takes one more item, then in_ready drops until the result is taken.
module square_channel_frequency_sweep_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [scfs_pkg::OpW-1:0]      opcode,
  input  logic [scfs_pkg::FreqW-1:0]    trigger_freq,
  input  logic [scfs_pkg::PeriodW-1:0]  period_value,
  input  logic                          negate_bit,
  input  logic [scfs_pkg::ShiftW-1:0]   shift_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          freq_write,
  output logic [scfs_pkg::FreqW-1:0]    freq_out,
  output logic                          channel_off,
  output logic                          sweep_enabled,
  output logic                          overflow_first,
  output logic                          overflow_second
);

  logic                         in_q;
  logic [scfs_pkg::OpW-1:0]     op_q;
  logic [scfs_pkg::FreqW-1:0]   trig_q;
  logic [scfs_pkg::PeriodW-1:0] period_q;
  logic                         negate_q;
  logic [scfs_pkg::ShiftW-1:0]  shift_q;

  logic [scfs_pkg::FreqW-1:0]   shadow, shadow_next;
  logic [scfs_pkg::CountW-1:0]  count, count_next;
  logic [scfs_pkg::PeriodW-1:0] period, period_next;
  logic [scfs_pkg::ShiftW-1:0]  shift, shift_next;
  logic                         sub_mode, sub_mode_next;
  logic                         sub_used, sub_used_next;
  logic                         en, en_next;
  logic                         ov1, ov1_next;
  logic                         ov2, ov2_next;
  logic                         write_next, off_next;

  logic                         advance, take;
  logic [scfs_pkg::FreqW-1:0]   base1, base2;
  logic [scfs_pkg::NextW-1:0]   next1, next2;
  logic [scfs_pkg::CountW-1:0]  reload, reload_new;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_q || advance;
  assign take     = in_q && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q <= 1'b0;
    end else if (in_ready) begin
      in_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q     <= opcode;
      trig_q   <= trigger_freq;
      period_q <= period_value;
      negate_q <= negate_bit;
      shift_q  <= shift_value;
    end
  end

  assign base1 = (op_q == scfs_pkg::OpTrigger) ? trig_q : shadow;
  assign base2 = (shift != '0) ? next1[scfs_pkg::FreqW-1:0] : shadow;

  scfs_calc u_calc_first (
    .freq      (base1),
    .shift     (shift),
    .sub       (sub_mode),
    .next_freq (next1)
  );

  scfs_calc u_calc_second (
    .freq      (base2),
    .shift     (shift),
    .sub       (sub_mode),
    .next_freq (next2)
  );

  assign reload     = (period != '0) ? {1'b0, period} : scfs_pkg::CountIdle;
  assign reload_new = (period_q != '0) ? {1'b0, period_q} : scfs_pkg::CountIdle;

  always_comb begin
    shadow_next   = shadow;
    count_next    = count;
    period_next   = period;
    shift_next    = shift;
    sub_mode_next = sub_mode;
    sub_used_next = sub_used;
    en_next       = en;
    ov1_next      = ov1;
    ov2_next      = ov2;
    write_next    = 1'b0;
    off_next      = 1'b0;
    case (op_q)
      scfs_pkg::OpTick: begin
        if (en) begin
          if (count <= 4'd1) begin
            count_next = reload;
            if (period != '0) begin
              if (sub_mode) begin
                sub_used_next = 1'b1;
              end
              if (!next1[scfs_pkg::FreqW]) begin
                if (shift != '0) begin
                  shadow_next = next1[scfs_pkg::FreqW-1:0];
                  write_next  = 1'b1;
                end
                if (next2[scfs_pkg::FreqW]) begin
                  ov2_next = 1'b1;
                end
              end else begin
                ov1_next = 1'b1;
                en_next  = 1'b0;
                off_next = 1'b1;
              end
            end
          end else begin
            count_next = count - 4'd1;
          end
        end
      end
      scfs_pkg::OpTrigger: begin
        shadow_next   = trig_q;
        count_next    = reload;
        sub_used_next = 1'b0;
        en_next       = (period != '0) || (shift != '0);
        ov1_next      = 1'b0;
        ov2_next      = 1'b0;
        if (shift != '0) begin
          if (sub_mode) begin
            sub_used_next = 1'b1;
          end
          if (next1[scfs_pkg::FreqW]) begin
            ov1_next = 1'b1;
          end
        end
      end
      scfs_pkg::OpPeriod: begin
        period_next = period_q;
        if (count == '0) begin
          count_next = reload_new;
        end
      end
      scfs_pkg::OpNegate: begin
        if (sub_used && !negate_q) begin
          sub_mode_next = 1'b0;
          off_next      = 1'b1;
        end else begin
          sub_mode_next = negate_q;
          sub_used_next = 1'b0;
        end
      end
      scfs_pkg::OpShift: begin
        shift_next = shift_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow   <= '0;
      count    <= '0;
      period   <= '0;
      shift    <= '0;
      sub_mode <= 1'b0;
      sub_used <= 1'b0;
      en       <= 1'b1;
      ov1      <= 1'b0;
      ov2      <= 1'b0;
    end else if (take) begin
      shadow   <= shadow_next;
      count    <= count_next;
      period   <= period_next;
      shift    <= shift_next;
      sub_mode <= sub_mode_next;
      sub_used <= sub_used_next;
      en       <= en_next;
      ov1      <= ov1_next;
      ov2      <= ov2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      freq_write      <= write_next;
      freq_out        <= shadow_next;
      channel_off     <= off_next;
      sweep_enabled   <= en_next;
      overflow_first  <= ov1_next;
      overflow_second <= ov2_next;
    end
  end

endmodule

@@ rtl/core/scfs_checker.sv @@
module scfs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       freq_write,
  input logic [scfs_pkg::FreqW-1:0] freq_out,
  input logic                       channel_off,
  input logic                       sweep_enabled
);

  a_write_enabled: assert property (@(posedge clk) disable iff (rst)
    out_valid && freq_write |-> sweep_enabled)
    else $error("frequency write with sweep disabled");

  a_write_not_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && freq_write |-> !channel_off)
    else $error("frequency write together with channel off");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(freq_out))
    else $error("result dropped or changed during stall");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind square_channel_frequency_sweep_core scfs_checker u_scfs_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .freq_write    (freq_write),
  .freq_out      (freq_out),
  .channel_off   (channel_off),
  .sweep_enabled (sweep_enabled)
);
